[src/bssf_pkg.sv]
// ----------------------------------------------------------------------------
// bssf_pkg
// Shared types and constants for the barometer sync checker and spike filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bssf_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned HoldW   = 4;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [HoldW-1:0]   hold_t;
  typedef logic [15:0]        count_t;

  localparam hold_t  HOLD_RESET = hold_t'(3);
  localparam count_t COUNT_MAX  = 16'hFFFF;

  // saturating increment
  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : count_t'(v + 16'd1);
  endfunction

endpackage : bssf_pkg

`default_nettype wire

[src/baro_sync_spike_filter_unit.sv]
// ----------------------------------------------------------------------------
// baro_sync_spike_filter_unit
// Barometer sync checker and spike filter, one frame beat in, one result out.
// ----------------------------------------------------------------------------
// Path: an accepted frame beat passes the input register, then the result
//   register, which holds the result while out_ready is low.
// Throughput: 1 frame per cycle while the result side keeps up (out_ready).
// Reset: rst_n synchronous, active low; clears all filter state, both counters and
//   the valid flags, and loads spike_hold_frames with 3.
`timescale 1ns / 1ps
`default_nettype none

module baro_sync_spike_filter_unit
  import bssf_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,

  // configuration: spike_hold_frames
  input  wire logic          cfg_valid,
  output      logic          cfg_ready,
  input  wire logic [3:0]    cfg_data,

  // frame beats
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire logic [15:0]   in_pressure_raw,
  input  wire logic [15:0]   in_temperature_raw,

  // result beats
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      logic [15:0]   out_pressure_out,
  output      logic [15:0]   out_temperature_out,
  output      logic          out_holding,
  output      logic [15:0]   out_sync_error_total,
  output      logic [15:0]   out_spike_total
);

  // --------------------------------------------------------------------------
  // Configuration register. Always ready; the user must write it only while idle, the block does not enforce this.
  // --------------------------------------------------------------------------
  hold_t hold_frames_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_frames_r <= HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hold_frames_r <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. The result register advances whenever it is empty or
  // being drained; the input register follows it. This gives a full beat per
  // cycle with no bubble while the result side keeps up.
  // --------------------------------------------------------------------------
  logic    s1_valid_r;
  sample_t s1_p_r;
  sample_t s1_t_r;
  logic    out_valid_r;
  logic    adv;       // result register takes a new value this cycle
  logic    eval;      // stage-1 frame is evaluated and state updated

  assign adv      = !out_valid_r || out_ready;
  assign eval     = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_p_r <= in_pressure_raw;
      s1_t_r <= in_temperature_raw;
    end
  end

  // --------------------------------------------------------------------------
  // Filter state
  // --------------------------------------------------------------------------
  sample_t prev_p_r, prev_p_nxt;
  sample_t prev_t_r, prev_t_nxt;
  sample_t good_p_r, good_p_nxt;
  sample_t good_t_r, good_t_nxt;
  logic    phase_r, phase_nxt;   // 1: expecting a new pressure
  hold_t   hold_cnt_r, hold_cnt_nxt;
  count_t  sync_cnt_r, sync_cnt_nxt;
  count_t  spike_cnt_r, spike_cnt_nxt;

  sample_t res_p, res_t;
  logic    res_hold;

  always_comb begin
    logic  sync_err;
    hold_t cnt;

    // Alternation check. A zero previous value means nothing seen yet, so
    // that phase's check is skipped.
    if (!phase_r) begin
      sync_err = (prev_p_r != '0) && (prev_p_r != s1_p_r);
    end else begin
      sync_err = (prev_t_r != '0) && (prev_t_r != s1_t_r);
    end
    // toggle on a clean frame, stay put on an error
    phase_nxt    = sync_err ? phase_r : !phase_r;
    sync_cnt_nxt = sync_err ? sat_inc(sync_cnt_r) : sync_cnt_r;

    prev_p_nxt = s1_p_r;
    prev_t_nxt = s1_t_r;

    // Spike: pressure equal to temperature reloads the hold, even mid-hold
    if (s1_p_r == s1_t_r) begin
      cnt           = hold_frames_r;
      spike_cnt_nxt = sat_inc(spike_cnt_r);
    end else begin
      cnt           = hold_cnt_r;
      spike_cnt_nxt = spike_cnt_r;
    end

    if (cnt != '0) begin
      res_p        = good_p_r;
      res_t        = good_t_r;
      res_hold     = 1'b1;
      hold_cnt_nxt = hold_t'(cnt - hold_t'(1));
      good_p_nxt   = good_p_r;
      good_t_nxt   = good_t_r;
    end else begin
      res_p        = s1_p_r;
      res_t        = s1_t_r;
      res_hold     = 1'b0;
      hold_cnt_nxt = cnt;
      good_p_nxt   = s1_p_r;
      good_t_nxt   = s1_t_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_p_r    <= '0;
      prev_t_r    <= '0;
      good_p_r    <= '0;
      good_t_r    <= '0;
      phase_r     <= 1'b0;
      hold_cnt_r  <= '0;
      sync_cnt_r  <= '0;
      spike_cnt_r <= '0;
    end else if (eval) begin
      prev_p_r    <= prev_p_nxt;
      prev_t_r    <= prev_t_nxt;
      good_p_r    <= good_p_nxt;
      good_t_r    <= good_t_nxt;
      phase_r     <= phase_nxt;
      hold_cnt_r  <= hold_cnt_nxt;
      sync_cnt_r  <= sync_cnt_nxt;
      spike_cnt_r <= spike_cnt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register. It parts the two sides, so a new frame is taken while
  // a finished result still waits.
  // --------------------------------------------------------------------------
  sample_t out_p_r, out_t_r;
  logic    out_hold_r;
  count_t  out_sync_r, out_spike_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (eval) begin
      out_p_r     <= res_p;
      out_t_r     <= res_t;
      out_hold_r  <= res_hold;
      out_sync_r  <= sync_cnt_nxt;
      out_spike_r <= spike_cnt_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_pressure_out     = out_p_r;
  assign out_temperature_out  = out_t_r;
  assign out_holding          = out_hold_r;
  assign out_sync_error_total = out_sync_r;
  assign out_spike_total      = out_spike_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a held result shows the pair still stored as last good
  a_hold_matches_good: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hold_r) |->
      (out_p_r == good_p_r && out_t_r == good_t_r))
    else $error("held result differs from last good pair");

  // counters never wrap
  a_sync_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (sync_cnt_r == COUNT_MAX) |=> (sync_cnt_r == COUNT_MAX))
    else $error("sync error counter wrapped");

  a_spike_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (spike_cnt_r == COUNT_MAX) |=> (spike_cnt_r == COUNT_MAX))
    else $error("spike counter wrapped");

  // state only moves when a frame is evaluated
  a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!eval && rst_n) |=> ($stable(phase_r) && $stable(hold_cnt_r)))
    else $error("filter state changed without a frame");

endmodule : baro_sync_spike_filter_unit

`default_nettype wire
